// ===== design/tsas_pkg.sv =====
// Shared types and constants of the travel, scan and align sequencer.
`timescale 1ns / 1ps
`default_nettype none
package tsas_pkg;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 21;

   localparam int MaxSpeedWidth  = 18;
   localparam int ScanRateWidth  = 19;
   localparam int ServoGainWidth = 21;
   localparam int TimeoutWidth   = 8;

   localparam logic [CsrIndexWidth-1:0] CsrMaxSpeed  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrScanRate  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrServoGain = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CsrTimeout   = 2'd3;

   localparam logic [MaxSpeedWidth-1:0]  MaxSpeedReset  = 18'd14418;
   localparam logic [ScanRateWidth-1:0]  ScanRateReset  = 19'd22938;
   localparam logic [ServoGainWidth-1:0] ServoGainReset = 21'd52429;
   localparam logic [TimeoutWidth-1:0]   TimeoutReset   = 8'd10;

   localparam logic signed [33:0] GoalDist   = 34'sd95027;
   localparam logic signed [33:0] StopBand   = 34'sd1311;
   localparam logic signed [33:0] SlowZone   = 34'sd32768;
   localparam logic [14:0]        SlowFactor = 15'd26214;
   localparam logic [14:0]        StopBandU  = 15'd1311;
   localparam logic signed [19:0] SlewStep   = 20'sd164;
   localparam logic [17:0]        StopSpeed  = 18'd655;
   localparam logic [32:0]        DeadBand   = 33'd328;
   localparam logic [36:0]        ServoClamp = 37'd13107;
   localparam logic [36:0]        ServoMin   = 37'd3277;
   localparam logic signed [31:0] FlipX      = 32'sd49152;
   localparam logic [7:0]         DoneTicks  = 8'd20;
   localparam logic [7:0]         LostTicks  = 8'd40;
   localparam logic [2:0]         PersistMin = 3'd3;
   localparam logic [52:0]        RoundHalf  = 53'd32768;

   typedef enum logic [1:0] {
      ModeStandby = 2'd0,
      ModeTravel  = 2'd1,
      ModeScan    = 2'd2,
      ModeAlign   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [MaxSpeedWidth-1:0]         max_speed;
      logic signed [ScanRateWidth-1:0]  scan_rate;
      logic [ServoGainWidth-1:0]        servo_gain;
      logic [TimeoutWidth-1:0]          timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic               odom_update;
      logic signed [31:0] position_x;
      logic               marker_update;
      logic signed [31:0] marker_error;
      logic               trigger;
   } item_type;

   typedef struct packed {
      logic signed [31:0] linear_out;
      logic signed [31:0] angular_out;
      logic               ready_res;
      logic [1:0]         mode;
   } result_type;

endpackage
`default_nettype wire

// ===== design/tsas_req_if.sv =====
// Input channel: one control tick per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface tsas_req_if;
   logic               valid;
   logic               ready;
   logic               odom_update;
   logic signed [31:0] position_x;
   logic               marker_update;
   logic signed [31:0] marker_error;
   logic               trigger;

   modport source (output valid, output odom_update, output position_x,
                   output marker_update, output marker_error, output trigger,
                   input ready);
   modport sink   (input valid, input odom_update, input position_x,
                   input marker_update, input marker_error, input trigger,
                   output ready);
endinterface
`default_nettype wire

// ===== design/tsas_rsp_if.sv =====
// Result channel: one command set per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface tsas_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] linear_out;
   logic signed [31:0] angular_out;
   logic               ready_res;
   logic [1:0]         mode;

   modport source (output valid, output linear_out, output angular_out,
                   output ready_res, output mode, input ready);
   modport sink   (input valid, input linear_out, input angular_out,
                   input ready_res, input mode, output ready);
endinterface
`default_nettype wire

// ===== design/tsas_csr_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps
`default_nettype none
interface tsas_csr_if
   import tsas_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/travel_scan_align_sequencer.sv =====
// Top level of the travel, scan and align sequencer.
//
// One transaction on req_chan is one control tick. The tick is held in an
// input register and, once the result register is free or being drained,
// the whole step (input merge, travel speed profile, scan lock, alignment
// servo with one 32x21 multiply) is evaluated in a single pass into the
// result register, so a tick is accepted every cycle unless rsp_chan
// back-pressure holds the pending tick. Ticks before the first odometry
// update produce no result. Configuration writes on csr_chan take effect
// in the cycle after the write and are always accepted.
`timescale 1ns / 1ps
`default_nettype none
module travel_scan_align_sequencer
   import tsas_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   tsas_req_if.sink    req_chan,
   tsas_rsp_if.source  rsp_chan,
   tsas_csr_if.sink    csr_chan
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type result_ff, step_result;
   logic       out_valid_ff, out_valid_in;
   logic       has_result;
   logic       advance, req_fire;

   tsas_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   tsas_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (item_ff),
      .cfg        (cfg),
      .has_result (has_result),
      .result     (step_result)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in.odom_update   = req_chan.odom_update;
      item_in.position_x    = req_chan.position_x;
      item_in.marker_update = req_chan.marker_update;
      item_in.marker_error  = req_chan.marker_error;
      item_in.trigger       = req_chan.trigger;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance && has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (advance && has_result) begin
         result_ff <= step_result;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.linear_out  = result_ff.linear_out;
   assign rsp_chan.angular_out = result_ff.angular_out;
   assign rsp_chan.ready_res   = result_ff.ready_res;
   assign rsp_chan.mode        = result_ff.mode;

   a_result_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("result raised without a pending tick");

   a_held_tick_stable: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(item_ff)))
      else $error("pending tick lost or overwritten");

   a_ready_mode: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.ready_res) |->
         (result_ff.mode == ModeStandby || result_ff.mode == ModeTravel))
      else $error("ready result with wrong mode");

   a_linear_only_travel: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.linear_out != '0) |-> (result_ff.mode == ModeTravel))
      else $error("linear command outside travel");

endmodule
`default_nettype wire

// ===== design/tsas_csr.sv =====
// Configuration registers of the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module tsas_csr
   import tsas_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   tsas_csr_if.sink  csr_chan,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CsrMaxSpeed:  cfg_in.max_speed     = csr_chan.data[MaxSpeedWidth-1:0];
            CsrScanRate:  cfg_in.scan_rate     = csr_chan.data[ScanRateWidth-1:0];
            CsrServoGain: cfg_in.servo_gain    = csr_chan.data[ServoGainWidth-1:0];
            CsrTimeout:   cfg_in.timeout_ticks = csr_chan.data[TimeoutWidth-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed     <= MaxSpeedReset;
         cfg_ff.scan_rate     <= ScanRateReset;
         cfg_ff.servo_gain    <= ServoGainReset;
         cfg_ff.timeout_ticks <= TimeoutReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/tsas_seq.sv =====
// Sequencer state and the single-pass step logic for one control tick.
`timescale 1ns / 1ps
`default_nettype none
module tsas_seq
   import tsas_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output logic          has_result,
   output result_type    result
);

   mode_type           mode_ff, mode_in;
   logic signed [31:0] position_ff, position_in;
   logic signed [31:0] start_ff, start_in;
   logic [17:0]        speed_ff, speed_in;
   logic signed [31:0] error_ff, error_in;
   logic [7:0]         age_ff, age_in;
   logic               seen_ff, seen_in;
   logic               odom_ff, odom_in;
   logic               trig_ff, trig_in;
   logic [2:0]         persist_ff, persist_in;
   logic [7:0]         align_ff, align_in;

   logic               seen_m, seen_live, trig_m;

   // travel datapath
   logic signed [32:0] delta;
   logic [32:0]        delta_abs;
   logic signed [33:0] goal_gap;
   logic               beyond_stop, in_slow;
   logic [29:0]        slow_prod;
   logic [14:0]        slow_raw, slow_target;
   logic [17:0]        target;
   logic signed [19:0] speed_step;
   logic [17:0]        speed_new;
   logic               travel_done;

   // align datapath
   logic [32:0]        err_abs;
   logic               outside_dead;
   logic [52:0]        servo_prod;
   logic [36:0]        servo_mag;
   logic [13:0]        servo_abs;
   logic               servo_neg;
   logic               ang_neg;
   logic signed [31:0] servo_ang;

   logic [2:0]         persist_inc;
   logic [7:0]         align_inc;
   logic               scan_lock, align_done, align_lost;

   // merge the new tick
   always_comb begin
      position_in = item.odom_update ? item.position_x : position_ff;
      odom_in     = odom_ff | item.odom_update;
      error_in    = item.marker_update ? item.marker_error : error_ff;
      if (item.marker_update) begin
         age_in = '0;
      end else if (age_ff != 8'hFF) begin
         age_in = age_ff + 8'd1;
      end else begin
         age_in = age_ff;
      end
      seen_m    = seen_ff | item.marker_update;
      seen_live = seen_m & ~(age_in > cfg.timeout_ticks);
      trig_m    = trig_ff | item.trigger;
   end

   // travel speed profile
   always_comb begin
      delta       = 33'(position_in) - 33'(start_ff);
      delta_abs   = delta[32] ? (~delta + 33'sd1) : delta;
      goal_gap    = GoalDist - $signed({1'b0, delta_abs});
      beyond_stop = goal_gap > StopBand;
      in_slow     = goal_gap < SlowZone;
      slow_prod   = 30'(goal_gap[14:0]) * 30'(SlowFactor);
      slow_raw    = 15'((31'(slow_prod) + 31'd32768) >> 16);
      slow_target = (slow_raw < StopBandU) ? StopBandU : slow_raw;
      if (!beyond_stop) begin
         target = '0;
      end else if (in_slow) begin
         target = 18'(slow_target);
      end else begin
         target = cfg.max_speed;
      end
      speed_step = (target > speed_ff) ? ($signed({2'b00, speed_ff}) + SlewStep)
                                       : ($signed({2'b00, speed_ff}) - SlewStep);
      if (speed_step < 20'sd0) begin
         speed_new = '0;
      end else if (speed_step[18:0] > 19'(cfg.max_speed)) begin
         speed_new = cfg.max_speed;
      end else begin
         speed_new = speed_step[17:0];
      end
      travel_done = !beyond_stop && (speed_new < StopSpeed);
   end

   // alignment servo
   always_comb begin
      err_abs      = error_in[31] ? (33'd0 - 33'(error_in)) : 33'(error_in);
      outside_dead = err_abs > DeadBand;
      servo_prod   = 53'(err_abs[31:0]) * 53'(cfg.servo_gain);
      servo_mag    = 37'((servo_prod + RoundHalf) >> 16);
      if (servo_mag > ServoClamp) begin
         servo_abs = 14'(ServoClamp);
      end else if (servo_mag < ServoMin) begin
         servo_abs = 14'(ServoMin);
      end else begin
         servo_abs = servo_mag[13:0];
      end
      servo_neg = (servo_mag == '0) ? 1'b1 : error_in[31];
      ang_neg   = servo_neg ^ (position_in < FlipX);
      servo_ang = ang_neg ? -$signed(32'(servo_abs)) : $signed(32'(servo_abs));
   end

   always_comb begin
      persist_inc = (persist_ff == 3'd7) ? persist_ff : persist_ff + 3'd1;
      align_inc   = (align_ff == 8'hFF) ? align_ff : align_ff + 8'd1;
      scan_lock   = seen_live && (persist_inc > PersistMin);
      align_done  = seen_live && !outside_dead && (align_inc > DoneTicks);
      align_lost  = !seen_live && (align_inc > LostTicks);
   end

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (odom_in) begin
         unique case (mode_ff)
            ModeStandby: if (trig_m) mode_in = ModeTravel;
            ModeTravel:  if (travel_done) mode_in = ModeScan;
            ModeScan:    if (scan_lock) mode_in = ModeAlign;
            ModeAlign: begin
               if (align_done) begin
                  mode_in = ModeStandby;
               end else if (align_lost) begin
                  mode_in = ModeScan;
               end
            end
            default:     mode_in = mode_ff;
         endcase
      end
   end

   // outputs and datapath state
   always_comb begin
      start_in   = start_ff;
      speed_in   = speed_ff;
      trig_in    = trig_m;
      persist_in = persist_ff;
      align_in   = align_ff;
      seen_in    = odom_in ? seen_live : seen_m;
      has_result = odom_in;
      result.linear_out  = '0;
      result.angular_out = '0;
      result.ready_res   = 1'b0;
      result.mode        = mode_in;
      if (odom_in) begin
         unique case (mode_ff)
            ModeStandby: begin
               result.ready_res = 1'b1;
               if (trig_m) begin
                  start_in = position_in;
                  trig_in  = 1'b0;
                  speed_in = '0;
               end
            end
            ModeTravel: begin
               if (travel_done) begin
                  speed_in   = '0;
                  persist_in = '0;
               end else begin
                  speed_in          = speed_new;
                  result.linear_out = $signed(32'(speed_new));
               end
            end
            ModeScan: begin
               if (seen_live) begin
                  persist_in = scan_lock ? 3'd0 : persist_inc;
               end else begin
                  persist_in         = '0;
                  result.angular_out = 32'(cfg.scan_rate);
               end
            end
            ModeAlign: begin
               if (seen_live && outside_dead) begin
                  result.angular_out = servo_ang;
                  align_in           = '0;
               end else begin
                  align_in = align_inc;
               end
            end
            default: result.ready_res = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ModeStandby;
         position_ff <= '0;
         start_ff    <= '0;
         speed_ff    <= '0;
         error_ff    <= '0;
         age_ff      <= '0;
         seen_ff     <= 1'b0;
         odom_ff     <= 1'b0;
         trig_ff     <= 1'b0;
         persist_ff  <= '0;
         align_ff    <= '0;
      end else if (step) begin
         mode_ff     <= mode_in;
         position_ff <= position_in;
         start_ff    <= start_in;
         speed_ff    <= speed_in;
         error_ff    <= error_in;
         age_ff      <= age_in;
         seen_ff     <= seen_in;
         odom_ff     <= odom_in;
         trig_ff     <= trig_in;
         persist_ff  <= persist_in;
         align_ff    <= align_in;
      end
   end

endmodule
`default_nettype wire

// ===== test/tb_travel_scan_align_sequencer.sv =====
// Self-checking testbench for the travel, scan and align sequencer with its own tick predictor.
`timescale 1ns / 1ps
module tb_travel_scan_align_sequencer;
   import tsas_pkg::*;

   localparam longint GoalSpan    = 95027;
   localparam longint StopWindow  = 1311;
   localparam longint SlowZoneQ   = 32768;
   localparam longint SlowGain    = 26214;
   localparam longint SlewQ       = 164;
   localparam longint CreepSpeed  = 655;
   localparam longint ErrDeadBand = 328;
   localparam longint TurnClamp   = 13107;
   localparam longint TurnMin     = 3277;
   localparam longint FlipPoint   = 49152;
   localparam int     SettleTicks = 20;
   localparam int     LostLimit   = 40;
   localparam int     LockTicks   = 3;
   localparam int     PhaseCount  = 7;
   localparam int     PhaseTicks  = 250;
   localparam int     HoldCycles  = 400;
   localparam int     DrainCycles = 8;

   typedef enum int {RxOpen, RxCoin, RxSparse, RxEvery3, RxHold} rx_pattern_type;

   class tick_scoreboard;
      cfg_type     cfg;
      mode_type    mode_q;
      longint      pos_q, start_q, speed_q, err_q;
      int unsigned age_q, persist_q, align_n;
      bit          marker_q, odom_q, trig_q;
      result_type  expected_q[$];
      int unsigned n_ticks, n_results, n_errors;
      int unsigned mode_ticks[4];

      function new();
         cfg.max_speed     = MaxSpeedReset;
         cfg.scan_rate     = ScanRateReset;
         cfg.servo_gain    = ServoGainReset;
         cfg.timeout_ticks = TimeoutReset;
         mode_q   = ModeStandby;
         pos_q    = 0;
         start_q  = 0;
         speed_q  = 0;
         err_q    = 0;
         age_q    = 0;
         persist_q = 0;
         align_n  = 0;
         marker_q = 0;
         odom_q   = 0;
         trig_q   = 0;
         n_ticks  = 0;
         n_results = 0;
         n_errors = 0;
         foreach (mode_ticks[i]) mode_ticks[i] = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function longint qmul(longint a, longint b);
         longint p;
         p = a * b;
         if (p < 0) return -((-p + 32768) >> 16);
         return (p + 32768) >> 16;
      endfunction

      function void write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] val);
         case (idx)
            CsrMaxSpeed:  cfg.max_speed     = val[MaxSpeedWidth-1:0];
            CsrScanRate:  cfg.scan_rate     = val[ScanRateWidth-1:0];
            CsrServoGain: cfg.servo_gain    = val[ServoGainWidth-1:0];
            CsrTimeout:   cfg.timeout_ticks = val[TimeoutWidth-1:0];
            default: ;
         endcase
      endfunction

      function void note_tick(item_type it);
         result_type r;
         longint lin, ang, d, goal_gap, target, ms, v, ae, sr;
         bit rdy;
         n_ticks++;
         if (it.odom_update) begin
            pos_q  = $signed(it.position_x);
            odom_q = 1'b1;
         end
         if (it.marker_update) begin
            err_q    = $signed(it.marker_error);
            age_q    = 0;
            marker_q = 1'b1;
         end else if (age_q < 255) begin
            age_q++;
         end
         if (it.trigger) trig_q = 1'b1;
         if (!odom_q) return;
         if (age_q > cfg.timeout_ticks) marker_q = 1'b0;
         lin = 0;
         ang = 0;
         rdy = 1'b0;
         case (mode_q)
            ModeTravel: begin
               ms = cfg.max_speed;
               d  = pos_q - start_q;
               if (d < 0) d = -d;
               goal_gap = GoalSpan - d;
               target   = 0;
               if (goal_gap > StopWindow) begin
                  if (goal_gap < SlowZoneQ) begin
                     target = qmul(SlowGain, goal_gap);
                     if (target < StopWindow) target = StopWindow;
                  end else begin
                     target = ms;
                  end
               end
               if (target > speed_q) speed_q += SlewQ;
               else speed_q -= SlewQ;
               if (speed_q < 0) speed_q = 0;
               if (speed_q > ms) speed_q = ms;
               lin = speed_q;
               if (goal_gap <= StopWindow && speed_q < CreepSpeed) begin
                  lin       = 0;
                  speed_q   = 0;
                  mode_q    = ModeScan;
                  persist_q = 0;
               end
            end
            ModeScan: begin
               if (marker_q) begin
                  if (persist_q < 7) persist_q++;
                  if (persist_q > LockTicks) begin
                     mode_q    = ModeAlign;
                     persist_q = 0;
                  end
               end else begin
                  persist_q = 0;
                  sr  = $signed(cfg.scan_rate);
                  ang = sr;
               end
            end
            ModeAlign: begin
               if (marker_q) begin
                  ae = (err_q < 0) ? -err_q : err_q;
                  if (ae > ErrDeadBand) begin
                     v = qmul(longint'(cfg.servo_gain), err_q);
                     if (v > TurnClamp) v = TurnClamp;
                     if (v < -TurnClamp) v = -TurnClamp;
                     if (v > -TurnMin && v < TurnMin) v = (v > 0) ? TurnMin : -TurnMin;
                     ang     = (pos_q < FlipPoint) ? -v : v;
                     align_n = 0;
                  end else begin
                     if (align_n < 255) align_n++;
                     if (align_n > SettleTicks) mode_q = ModeStandby;
                  end
               end else begin
                  if (align_n < 255) align_n++;
                  if (align_n > LostLimit) mode_q = ModeScan;
               end
            end
            default: begin
               rdy = 1'b1;
               if (trig_q) begin
                  start_q = pos_q;
                  trig_q  = 1'b0;
                  speed_q = 0;
                  mode_q  = ModeTravel;
               end
            end
         endcase
         r.linear_out  = lin[31:0];
         r.angular_out = ang[31:0];
         r.ready_res   = rdy;
         r.mode        = mode_q;
         mode_ticks[mode_q]++;
         expected_q.push_back(r);
      endfunction

      task report(string msg);
         n_errors++;
         if (n_errors <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing expected: lin %0d ang %0d mode %0d",
                             got.linear_out, got.angular_out, got.mode));
         end else begin
            want = expected_q.pop_front();
            n_results++;
            if (got.linear_out !== want.linear_out)
               report($sformatf("result %0d linear_out %0d, expected %0d",
                                n_results, got.linear_out, want.linear_out));
            if (got.angular_out !== want.angular_out)
               report($sformatf("result %0d angular_out %0d, expected %0d",
                                n_results, got.angular_out, want.angular_out));
            if (got.ready_res !== want.ready_res)
               report($sformatf("result %0d ready_res %b, expected %b",
                                n_results, got.ready_res, want.ready_res));
            if (got.mode !== want.mode)
               report($sformatf("result %0d mode %0d, expected %0d",
                                n_results, got.mode, want.mode));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   tsas_req_if req_if ();
   tsas_rsp_if rsp_if ();
   tsas_csr_if csr_if ();

   travel_scan_align_sequencer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   tick_scoreboard sb;
   int unsigned    seg_left;
   int unsigned    err_span;
   bit             quiet;
   bit             hold_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d results outstanding", sb.pending());
      $display("TEST FAILED");
      $finish;
   end

   function automatic item_type tick_of(bit odom, logic [31:0] pos, bit mk,
                                        logic [31:0] err, bit trg);
      item_type it;
      it.odom_update   = odom;
      it.position_x    = pos;
      it.marker_update = mk;
      it.marker_error  = err;
      it.trigger       = trg;
      return it;
   endfunction

   // Shape each tick after the predicted mode so that missions run end to end.
   function automatic item_type shaped_tick();
      item_type it;
      longint d, step, pos_next, e;
      if (seg_left == 0) begin
         seg_left = $urandom_range(8, 60);
         quiet    = ($urandom_range(0, 5) == 0);
         err_span = $urandom_range(0, 3);
      end
      seg_left--;
      if ($urandom_range(0, 9) == 0) begin
         it.odom_update   = $urandom_range(0, 1);
         it.position_x    = $urandom;
         it.marker_update = $urandom_range(0, 1);
         it.marker_error  = $urandom;
         it.trigger       = $urandom_range(0, 1);
         return it;
      end
      case (err_span)
         0: begin
            case ($urandom_range(0, 7))
               0: e = -2147483648;
               1: e = 2147483647;
               default: e = $signed($urandom);
            endcase
         end
         1: e = longint'($urandom_range(0, 600)) - 300;
         2: e = longint'($urandom_range(0, 656)) - 328;
         default: e = longint'($urandom_range(0, 40000)) - 20000;
      endcase
      it.marker_update = !quiet && ($urandom_range(0, 99) < 75);
      it.marker_error  = e[31:0];
      case (sb.mode_q)
         ModeTravel: begin
            d = sb.pos_q - sb.start_q;
            if (d > GoalSpan + 4000 || d < -(GoalSpan + 4000)) step = $urandom_range(0, 100);
            else step = $urandom_range(0, 3000);
            if (d < 0 || (d == 0 && $urandom_range(0, 1) == 1)) pos_next = sb.pos_q - step;
            else pos_next = sb.pos_q + step;
            it.odom_update = ($urandom_range(0, 9) != 0);
            it.trigger     = ($urandom_range(0, 11) == 0);
         end
         ModeScan, ModeAlign: begin
            pos_next       = sb.pos_q + longint'($urandom_range(0, 400)) - 200;
            it.odom_update = ($urandom_range(0, 4) == 0);
            it.trigger     = ($urandom_range(0, 11) == 0);
         end
         default: begin
            case ($urandom_range(0, 3))
               0, 1: pos_next = longint'($urandom_range(0, 400000)) - 200000;
               2: pos_next = FlipPoint + longint'($urandom_range(0, 4000)) - 2000;
               default: pos_next = $signed($urandom);
            endcase
            it.odom_update = ($urandom_range(0, 3) != 0);
            it.trigger     = ($urandom_range(0, 3) == 0);
         end
      endcase
      it.position_x = pos_next[31:0];
      return it;
   endfunction

   task automatic send_tick(input item_type it);
      req_if.valid         <= 1'b1;
      req_if.odom_update   <= it.odom_update;
      req_if.position_x    <= it.position_x;
      req_if.marker_update <= it.marker_update;
      req_if.marker_error  <= it.marker_error;
      req_if.trigger       <= it.trigger;
      do @(posedge clock); while (!req_if.ready);
      sb.note_tick(it);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      sb.write_reg(idx, val);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   initial begin : rsp_sink
      rx_pattern_type pat;
      int unsigned    seg_n, cyc_n;
      result_type     got;
      pat   = RxOpen;
      seg_n = 0;
      cyc_n = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.linear_out  = rsp_if.linear_out;
            got.angular_out = rsp_if.angular_out;
            got.ready_res   = rsp_if.ready_res;
            got.mode        = rsp_if.mode;
            sb.check_result(got);
         end
         if (seg_n == 0) begin
            if (hold_req) begin
               pat      = RxHold;
               seg_n    = HoldCycles;
               hold_req = 1'b0;
            end else begin
               pat   = rx_pattern_type'($urandom_range(0, 3));
               seg_n = $urandom_range(5, 60);
            end
         end
         seg_n--;
         cyc_n++;
         case (pat)
            RxOpen:   rsp_if.ready <= 1'b1;
            RxCoin:   rsp_if.ready <= $urandom_range(0, 1);
            RxSparse: rsp_if.ready <= ($urandom_range(0, 4) == 0);
            RxEvery3: rsp_if.ready <= (cyc_n % 3 == 0);
            default:  rsp_if.ready <= 1'b0;
         endcase
      end
   end

   initial begin : stimulus
      int unsigned burst, gap, n;
      sb       = new();
      seg_left = 0;
      err_span = 0;
      quiet    = 1'b0;
      hold_req = 1'b0;
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.odom_update   <= 1'b0;
      req_if.position_x    <= '0;
      req_if.marker_update <= 1'b0;
      req_if.marker_error  <= '0;
      req_if.trigger       <= 1'b0;
      csr_if.valid         <= 1'b0;
      csr_if.index         <= CsrMaxSpeed;
      csr_if.data          <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_tick(tick_of(1'b0, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1));
      send_tick(tick_of(1'b0, 32'h1234_5678, 1'b0, 32'h0000_0000, 1'b0));
      send_tick(tick_of(1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0));
      send_tick(tick_of(1'b1, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b1));
      repeat (4) send_tick(tick_of(1'b0, 32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0));
      send_tick(tick_of(1'b0, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0));
      send_tick(tick_of(1'b1, 32'h0000_C000, 1'b1, 32'h8000_0000, 1'b0));
      send_tick(tick_of(1'b0, 32'h0000_0000, 1'b1, 32'h0000_0148, 1'b0));
      send_tick(tick_of(1'b0, 32'h0000_0000, 1'b1, 32'hFFFF_FEB8, 1'b0));
      send_tick(tick_of(1'b0, 32'h0000_0000, 1'b1, 32'h0000_0149, 1'b0));
      send_tick(tick_of(1'b1, 32'hFFFF_0000, 1'b1, 32'hFFFF_FEB7, 1'b0));
      send_tick(tick_of(1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0));
      req_if.valid <= 1'b0;
      wait_idle();

      for (int phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0: ;
            1: begin
               write_reg(CsrMaxSpeed, '1);
               write_reg(CsrScanRate, CsrDataWidth'(-131072));
               write_reg(CsrServoGain, CsrDataWidth'(1048576));
               write_reg(CsrTimeout, '0);
            end
            2: begin
               write_reg(CsrMaxSpeed, '0);
               write_reg(CsrScanRate, CsrDataWidth'(131072));
               write_reg(CsrServoGain, '0);
               write_reg(CsrTimeout, CsrDataWidth'(255));
            end
            3: begin
               write_reg(CsrMaxSpeed, CsrDataWidth'(131072));
               write_reg(CsrScanRate, CsrDataWidth'(-262144));
               write_reg(CsrServoGain, '1);
               write_reg(CsrTimeout, CsrDataWidth'(1));
            end
            default: begin
               write_reg(CsrMaxSpeed, ($urandom_range(0, 3) == 0) ?
                         CsrDataWidth'($urandom) : CsrDataWidth'($urandom_range(0, 131072)));
               write_reg(CsrScanRate, CsrDataWidth'($urandom));
               write_reg(CsrServoGain, CsrDataWidth'($urandom_range(0, 1048576)));
               write_reg(CsrTimeout, CsrDataWidth'($urandom_range(0, 40)));
            end
         endcase
         hold_req = 1'b1;
         n = 0;
         while (n < PhaseTicks) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
               send_tick(shaped_tick());
               n++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_if.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_if.valid <= 1'b0;
         wait_idle();
      end

      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected results never arrived", sb.pending()));
      $display("Sent %0d ticks over %0d register settings, checked %0d command results",
               sb.n_ticks, PhaseCount, sb.n_results);
      $display("Results by mode: standby %0d, travel %0d, scan %0d, align %0d; mismatches %0d",
               sb.mode_ticks[ModeStandby], sb.mode_ticks[ModeTravel],
               sb.mode_ticks[ModeScan], sb.mode_ticks[ModeAlign], sb.n_errors);
      if (sb.n_errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
